// ===== hdl/bgpm_pkg.sv =====
// Shared constants and types for the binary greedy plane mesher.
// No dependencies; every other file in hdl/ imports this package.
package bgpm_pkg;

  localparam int PLANE_SIZE = 16;
  localparam int IDX_W      = $clog2(PLANE_SIZE);
  localparam int LEN_W      = $clog2(PLANE_SIZE + 1);
  localparam int VTX_W      = 32;
  localparam int VTX_STEP   = 4;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_MERGE = 1'b1;

  typedef logic [PLANE_SIZE-1:0] row_t;

  typedef struct packed {
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] len;
    row_t             mask;
  } run_info_t;

  typedef struct packed {
    logic wr_en;
    logic clr_en;
  } plane_cmd_t;

endpackage

// ===== hdl/bgpm_run_find.sv =====
// Run finder: isolates the lowest run of set bits in a plane row.
// Depends on bgpm_pkg.
module bgpm_run_find import bgpm_pkg::*; (
  input  row_t      row,
  output run_info_t run
);

  row_t sum;
  row_t low;

  // Adding the lowest set bit ripples through the run; the bits that flip are the run.
  assign low = row & (~row + row_t'(1));
  assign sum = row + low;

  always_comb begin
    run.mask  = row & (row ^ sum);
    run.len   = LEN_W'($countones(run.mask));
    run.start = '0;
    for (int b = 0; b < PLANE_SIZE; b++) begin
      if (low[b]) run.start = IDX_W'(b);
    end
  end

endmodule

// ===== hdl/bgpm_plane.sv =====
// Occupancy plane: row storage, row writes, run extension and run clearing.
// Depends on bgpm_pkg.
module bgpm_plane import bgpm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  plane_cmd_t       cmd,
  input  logic [IDX_W-1:0] idx,
  input  row_t             wr_row,
  input  row_t             mask,
  output row_t             rd_row,
  output logic [LEN_W-1:0] ulen
);

  row_t             rows [PLANE_SIZE];
  row_t             holds;
  row_t             follow;
  logic [IDX_W-1:0] tail;
  logic [LEN_W:0]   span_end;
  row_t             covered;

  assign rd_row = rows[idx];

  always_comb begin
    for (int j = 0; j < PLANE_SIZE; j++) begin
      holds[j] = ((rows[j] & mask) == mask);
    end
    // Rows after idx, lowest first; rows past the plane shift in as zero.
    follow = (holds >> idx) >> 1;
    tail   = IDX_W'(PLANE_SIZE - 1);
    for (int k = PLANE_SIZE - 1; k >= 0; k--) begin
      if (!follow[k]) tail = IDX_W'(k);
    end
    ulen     = LEN_W'(tail) + LEN_W'(1);
    span_end = (LEN_W+1)'(idx) + (LEN_W+1)'(ulen);
    for (int j = 0; j < PLANE_SIZE; j++) begin
      covered[j] = (IDX_W'(j) >= idx) && ((LEN_W+1)'(j) < span_end);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < PLANE_SIZE; j++) rows[j] <= '0;
    end else if (cmd.wr_en) begin
      rows[idx] <= wr_row;
    end else if (cmd.clr_en) begin
      for (int j = 0; j < PLANE_SIZE; j++) begin
        if (covered[j]) rows[j] <= rows[j] & ~mask;
      end
    end
  end

endmodule

// ===== hdl/binary_greedy_plane_mesher_top.sv =====
// Top level of the binary greedy plane mesher: merge sequencer and result registers.
// Depends on bgpm_pkg, bgpm_run_find and bgpm_plane.
//
//   channel   direction  handshake            payload
//   request   in         start & !busy        req_type, row_index, row_bits
//   result    out        strobe, one cycle    rect_valid, rect_u, rect_v, rect_u_len,
//                                             rect_v_len, first_vertex, last_of_row
//
// A row write leaves busy low.
// A merge yields one rectangle per start-row run (at most 8 for a 16-bit row) or one empty
// result for an empty row; the plane compare against all later rows resolves one run per cycle.
// Each result appears in the cycle after its merge step; busy drops with the last one.
// Reset clears the plane and the vertex counter; results cannot be stalled.
module binary_greedy_plane_mesher_top import bgpm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             req_type,
  input  logic [IDX_W-1:0] row_index,
  input  logic [15:0]      row_bits,
  output logic             strobe,
  output logic             rect_valid,
  output logic [3:0]       rect_u,
  output logic [3:0]       rect_v,
  output logic [4:0]       rect_u_len,
  output logic [4:0]       rect_v_len,
  output logic [31:0]      first_vertex,
  output logic             last_of_row
);

  typedef enum logic {S_IDLE, S_MERGE} state_t;

  state_t           state;
  logic             first;
  logic [IDX_W-1:0] u;
  logic [VTX_W-1:0] vertex_counter;

  plane_cmd_t       cmd;
  logic [IDX_W-1:0] plane_idx;
  row_t             rd_row;
  logic [LEN_W-1:0] ulen;
  run_info_t        run;
  logic             accept;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign plane_idx = busy ? u : row_index;

  always_comb begin
    cmd.wr_en  = accept && (req_type == REQ_WRITE);
    cmd.clr_en = (state == S_MERGE) && (rd_row != '0);
  end

  bgpm_run_find u_run (
    .row (rd_row),
    .run (run)
  );

  bgpm_plane u_plane (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .idx    (plane_idx),
    .wr_row (row_bits[PLANE_SIZE-1:0]),
    .mask   (run.mask),
    .rd_row (rd_row),
    .ulen   (ulen)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      first          <= 1'b0;
      vertex_counter <= '0;
      strobe         <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && (req_type == REQ_MERGE)) begin
            u     <= row_index;
            first <= 1'b1;
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          first  <= 1'b0;
          strobe <= 1'b1;
          if (first && (rd_row == '0)) begin
            rect_valid   <= 1'b0;
            rect_u       <= '0;
            rect_v       <= '0;
            rect_u_len   <= '0;
            rect_v_len   <= '0;
            first_vertex <= '0;
            last_of_row  <= 1'b1;
            state        <= S_IDLE;
          end else begin
            rect_valid     <= 1'b1;
            rect_u         <= u;
            rect_v         <= run.start;
            rect_u_len     <= ulen;
            rect_v_len     <= run.len;
            first_vertex   <= vertex_counter;
            vertex_counter <= vertex_counter + VTX_W'(VTX_STEP);
            last_of_row    <= ((rd_row & ~run.mask) == '0);
            // Leave once the start row has no set bits left.
            if ((rd_row & ~run.mask) == '0) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !rect_valid |-> last_of_row)
    else $error("empty-row result not marked last");

  a_rect_nonzero: assert property (@(posedge clk) disable iff (rst)
    strobe && rect_valid |-> (rect_u_len != 5'd0) && (rect_v_len != 5'd0))
    else $error("rectangle with zero extent");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    strobe && rect_valid && !last_of_row |-> busy)
    else $error("merge ended before last result");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_WRITE) |=> !strobe)
    else $error("row write produced a result");

  a_merge_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_MERGE) |=> busy && !strobe)
    else $error("merge request not started");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for binary_greedy_plane_mesher_top: row writes and merges, directed then
// random, checked against an occupancy-plane model kept inside the bench. Depends on bgpm_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bgpm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 436;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] row;
    logic [15:0]      bits;
    logic             drain;
  } mesh_req_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  u;
    logic [3:0]  v;
    logic [4:0]  ulen;
    logic [4:0]  vlen;
    logic [31:0] fv;
    logic        last;
  } rect_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             req_type = REQ_WRITE;
  logic [IDX_W-1:0] row_index = '0;
  logic [15:0]      row_bits = '0;
  logic             busy;
  logic             strobe;
  logic             rect_valid;
  logic [3:0]       rect_u;
  logic [3:0]       rect_v;
  logic [4:0]       rect_u_len;
  logic [4:0]       rect_v_len;
  logic [31:0]      first_vertex;
  logic             last_of_row;

  binary_greedy_plane_mesher_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .row_index(row_index), .row_bits(row_bits),
    .strobe(strobe), .rect_valid(rect_valid), .rect_u(rect_u), .rect_v(rect_v),
    .rect_u_len(rect_u_len), .rect_v_len(rect_v_len), .first_vertex(first_vertex),
    .last_of_row(last_of_row)
  );

  mesh_req_t   req_queue[$];
  rect_t       rect_queue[$];
  logic [15:0] plane_model[PLANE_SIZE];
  logic [31:0] vertex_model = '0;

  int cycles = 0;
  int errors = 0;
  int pushed = 0;
  int accepted = 0;
  int merges = 0;
  int rects = 0;
  int empties = 0;
  int max_area = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // Model one accepted request: update the plane and queue the rectangles it yields.
  task automatic mesh_request(input mesh_req_t r);
    logic [15:0] row;
    logic [15:0] mask;
    int u, b, vstart, vlen, ulen;
    rect_t e;
    u = int'(r.row);
    if (r.kind == REQ_WRITE) begin
      plane_model[u] = r.bits;
      return;
    end
    merges++;
    if (plane_model[u] == '0) begin
      e = '0;
      e.last = 1'b1;
      rect_queue = {rect_queue, e};
      empties++;
      return;
    end
    while (plane_model[u] != '0) begin
      row = plane_model[u];
      vstart = 0;
      while (!row[vstart]) vstart++;
      mask = '0;
      vlen = 0;
      for (b = vstart; b < PLANE_SIZE; b++) begin
        if (row[b] && b == vstart + vlen) begin
          mask[b] = 1'b1;
          vlen++;
        end
      end
      ulen = 1;
      while (u + ulen < PLANE_SIZE && (plane_model[u + ulen] & mask) == mask) ulen++;
      for (b = 0; b < ulen; b++) plane_model[u + b] &= ~mask;
      e.valid = 1'b1;
      e.u     = 4'(u);
      e.v     = 4'(vstart);
      e.ulen  = 5'(ulen);
      e.vlen  = 5'(vlen);
      e.fv    = vertex_model;
      e.last  = (plane_model[u] == '0);
      rect_queue = {rect_queue, e};
      vertex_model += 32'(VTX_STEP);
      rects++;
      if (ulen * vlen > max_area) max_area = ulen * vlen;
    end
  endtask

  function automatic string fmt_rect(input rect_t r);
    return $sformatf("valid=%0b u=%0d v=%0d ulen=%0d vlen=%0d fv=%0d last=%0b",
                     r.valid, r.u, r.v, r.ulen, r.vlen, r.fv, r.last);
  endfunction

  // Driver: bursts of transfers separated by random gaps.
  mesh_req_t cur_req;
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : driver
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        mesh_request(cur_req);
        accepted++;
      end
      if (start && busy) begin
        // hold the request until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (req_queue.size() == 0 ||
                   (req_queue[0].drain && rect_queue.size() != 0)) begin
        start <= 1'b0;
      end else begin
        cur_req = req_queue.pop_front();
        start     <= 1'b1;
        req_type  <= cur_req.kind;
        row_index <= cur_req.row;
        row_bits  <= cur_req.bits;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
    end
  end

  // Monitor: every strobe is a transfer that cannot be stalled.
  always @(posedge clk) begin : monitor
    rect_t seen;
    rect_t want;
    if (!rst && strobe) begin
      seen = {rect_valid, rect_u, rect_v, rect_u_len, rect_v_len, first_vertex, last_of_row};
      if (rect_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", fmt_rect(seen));
      end else begin
        want = rect_queue.pop_front();
        if (seen !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %s\n          actual   %s",
                     fmt_rect(want), fmt_rect(seen));
        end
      end
    end
  end

  task automatic push_req(input logic kind, input int row, input logic [15:0] bits,
                          input logic drain);
    mesh_req_t r;
    r.kind  = kind;
    r.row   = IDX_W'(row);
    r.bits  = bits;
    r.drain = drain;
    req_queue = {req_queue, r};
    pushed++;
  endtask

  initial begin : stimulus
    int base, rows, hi, k, pick, len, pos;
    logic [15:0] shape, bits;
    for (k = 0; k < PLANE_SIZE; k++) plane_model[k] = '0;

    // Directed: empty plane, last-row stop, eight runs, split runs, overwrite, zero row.
    push_req(REQ_MERGE, 5, 16'h0000, 1'b0);
    push_req(REQ_WRITE, 15, 16'hFFFF, 1'b0);
    push_req(REQ_MERGE, 15, 16'h0000, 1'b0);
    for (k = 12; k < 16; k++) push_req(REQ_WRITE, k, 16'h0FF0, 1'b0);
    push_req(REQ_MERGE, 12, 16'h0000, 1'b0);
    push_req(REQ_WRITE, 0, 16'h5555, 1'b1);
    push_req(REQ_WRITE, 1, 16'hAAAA, 1'b0);
    push_req(REQ_MERGE, 0, 16'hFFFF, 1'b0);
    push_req(REQ_MERGE, 1, 16'h0000, 1'b0);
    push_req(REQ_WRITE, 2, 16'h8001, 1'b0);
    push_req(REQ_WRITE, 3, 16'hFFFF, 1'b0);
    push_req(REQ_MERGE, 2, 16'h0000, 1'b0);
    push_req(REQ_MERGE, 3, 16'h0000, 1'b1);
    push_req(REQ_WRITE, 7, 16'h0000, 1'b0);
    push_req(REQ_MERGE, 7, 16'h0000, 1'b0);
    push_req(REQ_WRITE, 8, 16'hFFFF, 1'b0);
    push_req(REQ_WRITE, 8, 16'h0001, 1'b0);
    push_req(REQ_MERGE, 8, 16'h0000, 1'b0);
    push_req(REQ_MERGE, 0, 16'h0000, 1'b0);

    k = pushed;
    while (pushed - k < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        // Stack a shape over several rows so merges extend, then merge them.
        base = $urandom_range(0, PLANE_SIZE - 1);
        hi = PLANE_SIZE - base;
        if (hi > 5 && $urandom_range(0, 7) != 0) hi = 5;
        rows = $urandom_range(1, hi);
        case ($urandom_range(0, 3))
          0: shape = 16'($urandom);
          1: shape = 16'($urandom & $urandom);
          2: shape = 16'hFFFF;
          default: begin
            len = $urandom_range(1, 16);
            pos = $urandom_range(0, 16 - len);
            shape = 16'(((17'h1 << len) - 17'h1) << pos);
          end
        endcase
        for (int r = 0; r < rows; r++) begin
          bits = shape;
          if ($urandom_range(0, 2) == 0) bits |= 16'($urandom & $urandom & $urandom);
          if ($urandom_range(0, 3) == 0) bits &= ~(16'h1 << $urandom_range(0, 15));
          push_req(REQ_WRITE, base + r, bits, $urandom_range(0, 11) == 0);
        end
        // Broken sequence: merge out of order or not at all.
        if (pick == 7) begin
          for (int r = rows - 1; r >= 0; r--)
            if ($urandom_range(0, 1) == 0)
              push_req(REQ_MERGE, base + r, 16'($urandom), 1'b0);
        end else begin
          for (int r = 0; r < rows; r++) push_req(REQ_MERGE, base + r, 16'($urandom), 1'b0);
        end
      end else begin
        push_req(1'($urandom_range(0, 1)), $urandom_range(0, 15), 16'($urandom), 1'b0);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (!(req_queue.size() == 0 && !start && rect_queue.size() == 0) &&
           cycles < CYCLE_LIMIT)
      @(posedge clk);

    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d requests and %0d results outstanding",
               req_queue.size(), rect_queue.size());
      $display("binary_greedy_plane_mesher_top verification failed");
    end else begin
      repeat (16) @(posedge clk);
      errors += rect_queue.size();
      $display("%0d requests transferred, %0d merges: %0d rectangles, %0d empty rows",
               accepted, merges, rects, empties);
      $display("largest rectangle %0d cells, final vertex index %0d, %0d mismatches",
               max_area, vertex_model, errors);
      if (errors == 0) begin
        $display("binary_greedy_plane_mesher_top verification clean");
      end else begin
        $display("binary_greedy_plane_mesher_top verification failed");
      end
    end
    $finish;
  end

endmodule
